// File: hdl/ssag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_pkg: shared types and constants for the strided slice address generator
// Holds the configuration register codes, the controller state type, the
// command and status bundles, and the packed-field helper.
// ----------------------------------------------------------------------------
package ssag_pkg;

    // Layout of the packed configuration words.
    localparam int PACKED_FIELDS = 4;
    localparam int FIELD_W       = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int RANK_W        = 3;
    localparam int OUT_INDEX_W   = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK        = 3'd0,
        REG_IN_DIMS     = 3'd1,
        REG_OUT_DIMS    = 3'd2,
        REG_BEGIN_LIST  = 3'd3,
        REG_STRIDE_LIST = 3'd4
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic mul;
        logic acc;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic dim_last;
    } sts_t;

    // Extract packed field idx, where field zero sits in the top bits.
    function automatic logic [FIELD_W-1:0] field_get(
        input logic [CFG_DATA_W-1:0] packed_word,
        input logic [1:0]            idx
    );
        logic [FIELD_W-1:0] f;
        case (idx)
            2'd0:    f = packed_word[63:48];
            2'd1:    f = packed_word[47:32];
            2'd2:    f = packed_word[31:16];
            default: f = packed_word[15:0];
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// File: hdl/ssag_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_ctrl: sequencing controller
// Walks one request through the per-dimension multiply and accumulate steps
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module ssag_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire ssag_pkg::sts_t sts,
    output ssag_pkg::cmd_t      cmd
);
    import ssag_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (sts.empty)
                    state_next = ST_FIN;
                else
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (sts.dim_last)
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_FIN:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag: set on load, cleared when the result is taken.
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: hdl/ssag_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_datapath: configuration, odometer and index arithmetic
// Holds the configuration registers and output coordinates, folds one
// dimension at a time into the source and destination indices with a
// multiply step and an accumulate step, and keeps the registered result.
// ----------------------------------------------------------------------------
module ssag_datapath #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ssag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              restart,
    input  wire ssag_pkg::cmd_t                    cmd,
    output ssag_pkg::sts_t                         sts,
    output logic [ssag_pkg::OUT_INDEX_W-1:0]       source_index,
    output logic [ssag_pkg::OUT_INDEX_W-1:0]       dest_index,
    output logic                                   last,
    output logic                                   out_of_range
);
    import ssag_pkg::*;

    localparam int RANK_LIM  = (MAX_RANK < PACKED_FIELDS) ? MAX_RANK : PACKED_FIELDS;
    localparam int DIM_IDX_W = (RANK_LIM > 1) ? $clog2(RANK_LIM) : 1;
    localparam int IDX_W     = (INDEX_BITS < OUT_INDEX_W) ? INDEX_BITS : OUT_INDEX_W;
    localparam int PROD_W    = FIELD_W + DIM_BITS + 1;
    localparam int X_W       = PROD_W + 1;
    localparam int BN_W      = FIELD_W + 2;

    // Configuration registers.
    logic [RANK_W-1:0]     rank_reg;
    logic [CFG_DATA_W-1:0] in_dims_reg;
    logic [CFG_DATA_W-1:0] out_dims_reg;
    logic [CFG_DATA_W-1:0] begin_list_reg;
    logic [CFG_DATA_W-1:0] stride_list_reg;

    // Odometer and iteration state.
    logic [DIM_BITS-1:0]  coord_reg  [RANK_LIM];
    logic [DIM_BITS-1:0]  coord_next [RANK_LIM];
    logic [DIM_IDX_W-1:0] dim_reg;
    logic [IDX_W-1:0]     src_reg;
    logic [IDX_W-1:0]     dst_reg;
    logic                 oor_reg;
    logic [IDX_W-1:0]     src_mul_reg;
    logic [IDX_W-1:0]     dst_mul_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [BN_W-1:0]   bn_reg;

    // Result register payload.
    logic [OUT_INDEX_W-1:0] source_index_reg;
    logic [OUT_INDEX_W-1:0] dest_index_reg;
    logic                   last_reg;
    logic                   out_of_range_reg;

    // Per-dimension combinational values.
    logic [RANK_W-1:0]    rank_eff;
    logic [DIM_IDX_W-1:0] last_dim;
    logic [DIM_BITS-1:0]  osz_all [RANK_LIM];
    logic [RANK_LIM-1:0]  at_end;
    logic [RANK_LIM-1:0]  in_use;
    logic                 empty;
    logic                 last_all;
    logic [DIM_BITS-1:0]  isz;
    logic [DIM_BITS-1:0]  osz;
    logic [DIM_BITS-1:0]  y;
    logic signed [FIELD_W-1:0] st;
    logic signed [FIELD_W-1:0] bgn;
    logic signed [BN_W-1:0]    isz_s;
    logic signed [BN_W-1:0]    b_wrap;
    logic signed [BN_W-1:0]    lo;
    logic signed [BN_W-1:0]    hi;
    logic signed [BN_W-1:0]    bn_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [X_W-1:0]     x;
    logic                      oor_dim;
    logic                      carry;

    // Configuration writes; codes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= RANK_W'(1);
            in_dims_reg     <= '0;
            out_dims_reg    <= '0;
            begin_list_reg  <= '0;
            stride_list_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANK:        rank_reg        <= cfg_data[RANK_W-1:0];
                REG_IN_DIMS:     in_dims_reg     <= cfg_data;
                REG_OUT_DIMS:    out_dims_reg    <= cfg_data;
                REG_BEGIN_LIST:  begin_list_reg  <= cfg_data;
                REG_STRIDE_LIST: stride_list_reg <= cfg_data;
                default:         rank_reg        <= rank_reg;
            endcase
        end
    end

    // Effective rank: zero acts as one, large values saturate.
    always_comb
    begin
        if (rank_reg == '0)
            rank_eff = RANK_W'(1);
        else if (rank_reg > RANK_W'(RANK_LIM))
            rank_eff = RANK_W'(RANK_LIM);
        else
            rank_eff = rank_reg;
    end

    assign last_dim = DIM_IDX_W'(rank_eff - RANK_W'(1));

    // Output sizes, end-of-dimension flags, empty and last detection.
    always_comb
    begin
        empty    = 1'b0;
        last_all = 1'b1;
        for (int d = 0; d < RANK_LIM; d++)
        begin
            osz_all[d] = DIM_BITS'(field_get(out_dims_reg, 2'(d)));
            in_use[d]  = RANK_W'(d) < rank_eff;
            at_end[d]  = ({1'b0, coord_reg[d]} + (DIM_BITS+1)'(1)) >= {1'b0, osz_all[d]};
            if (in_use[d] && (osz_all[d] == '0))
                empty = 1'b1;
            if (in_use[d] && !at_end[d])
                last_all = 1'b0;
        end
    end

    // Odometer advance, innermost dimension first.
    always_comb
    begin
        carry = 1'b1;
        for (int d = RANK_LIM - 1; d >= 0; d--)
        begin
            coord_next[d] = coord_reg[d];
            if (empty)
            begin
                coord_next[d] = '0;
            end
            else if (in_use[d] && carry)
            begin
                if (at_end[d])
                begin
                    coord_next[d] = '0;
                end
                else
                begin
                    coord_next[d] = coord_reg[d] + DIM_BITS'(1);
                    carry         = 1'b0;
                end
            end
        end
    end

    // Values of the dimension being folded in.
    assign isz = DIM_BITS'(field_get(in_dims_reg, 2'(dim_reg)));
    assign osz = DIM_BITS'(field_get(out_dims_reg, 2'(dim_reg)));
    assign st  = $signed(field_get(stride_list_reg, 2'(dim_reg)));
    assign bgn = $signed(field_get(begin_list_reg, 2'(dim_reg)));
    assign y   = coord_reg[dim_reg];

    // Begin normalization: wrap a negative begin, then clamp by stride sign.
    always_comb
    begin
        isz_s  = $signed({2'b00, FIELD_W'(isz)});
        b_wrap = BN_W'(bgn);
        if (bgn < 0)
            b_wrap = BN_W'(bgn) + isz_s;
        lo = (st < 0) ? -BN_W'(1) : '0;
        hi = (st < 0) ? (isz_s - BN_W'(1)) : isz_s;
        bn_next = b_wrap;
        if (bn_next < lo)
            bn_next = lo;
        if (bn_next > hi)
            bn_next = hi;
    end

    // Stride times coordinate.
    assign prod_next = st * $signed({1'b0, y});

    // Source coordinate and its range check.
    assign x       = X_W'(bn_reg) + X_W'(prod_reg);
    assign oor_dim = x[X_W-1] || (x[X_W-2:0] >= (X_W-1)'(isz));

    // Iteration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= '0;
            oor_reg <= 1'b0;
            for (int d = 0; d < RANK_LIM; d++)
                coord_reg[d] <= '0;
        end
        else if (cmd.start)
        begin
            dim_reg <= '0;
            oor_reg <= 1'b0;
            if (restart)
                for (int d = 0; d < RANK_LIM; d++)
                    coord_reg[d] <= '0;
        end
        else if (cmd.acc)
        begin
            dim_reg <= dim_reg + DIM_IDX_W'(1);
            if (oor_dim)
                oor_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            for (int d = 0; d < RANK_LIM; d++)
                coord_reg[d] <= coord_next[d];
        end
    end

    // Index accumulators and multiplier pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (cmd.mul)
        begin
            src_mul_reg <= src_reg * IDX_W'(isz);
            dst_mul_reg <= dst_reg * IDX_W'(osz);
            prod_reg    <= prod_next;
            bn_reg      <= bn_next;
        end
        else if (cmd.acc)
        begin
            if (!oor_dim)
                src_reg <= src_mul_reg + IDX_W'(x[X_W-2:0]);
            dst_reg <= dst_mul_reg + IDX_W'(y);
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (empty)
            begin
                source_index_reg <= '0;
                dest_index_reg   <= '0;
                last_reg         <= 1'b1;
                out_of_range_reg <= 1'b1;
            end
            else
            begin
                source_index_reg <= oor_reg ? '0 : OUT_INDEX_W'(src_reg);
                dest_index_reg   <= OUT_INDEX_W'(dst_reg);
                last_reg         <= last_all;
                out_of_range_reg <= oor_reg;
            end
        end
    end

    assign sts.empty    = empty;
    assign sts.dim_last = (dim_reg == last_dim);

    assign source_index = source_index_reg;
    assign dest_index   = dest_index_reg;
    assign last         = last_reg;
    assign out_of_range = out_of_range_reg;

endmodule
`default_nettype wire

// File: hdl/strided_slice_address_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strided_slice_address_gen: strided slice address generator
// Produces, for each request, the source and destination linear indices of
// the next element of a strided slice of a row-major tensor of up to four
// dimensions, with last and out-of-range flags.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in         in_valid/in_ready    restart
//  out      out        out_valid/out_ready  source_index, dest_index, last,
//                                           out_of_range
//
// A request takes one multiply step and one accumulate step per dimension
// in use, between its accept step and its result-load step; an empty output
// tensor goes from its single multiply step straight to the load step.
// The input is not ready again until the request in work loads its result.
// Reset clears the configuration to its defaults and the coordinates to zero.
// A stalled result stays in the output register; the next request is
// accepted meanwhile and waits at its load cycle until the register frees.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module strided_slice_address_gen #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ssag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ssag_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             restart,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ssag_pkg::OUT_INDEX_W-1:0]      source_index,
    output logic [ssag_pkg::OUT_INDEX_W-1:0]      dest_index,
    output logic                                  last,
    output logic                                  out_of_range
);
    import ssag_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Configuration port never stalls.
    assign cfg_ready = 1'b1;

    // Controller.
    ssag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    ssag_datapath #(
        .MAX_RANK   (MAX_RANK),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .restart      (restart),
        .cmd          (cmd),
        .sts          (sts),
        .source_index (source_index),
        .dest_index   (dest_index),
        .last         (last),
        .out_of_range (out_of_range)
    );

endmodule
`default_nettype wire

// File: hdl/ssag_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_checker: port-level checks for the strided slice address generator
// Watches the top-level ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
module ssag_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [ssag_pkg::OUT_INDEX_W-1:0] source_index,
    input wire logic [ssag_pkg::OUT_INDEX_W-1:0] dest_index,
    input wire logic                             last,
    input wire logic                             out_of_range
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(source_index)
            && $stable(dest_index) && $stable(last) && $stable(out_of_range))
        else $error("stalled result changed");

    // An out-of-range result carries a zero source index.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> source_index == '0)
        else $error("out-of-range result with nonzero source index");

    // A request in work blocks the input for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after acceptance");

    // A new result only appears at the end of a request's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind strided_slice_address_gen ssag_checker u_ssag_checker (.*);
`default_nettype wire
